// ----- rtl/mlpcls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpcls_pkg
// Shared types and constants of the two-layer perceptron classifier.
// ----------------------------------------------------------------------------
package mlpcls_pkg;

  // item kinds
  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  localparam int WORD_W    = 16;
  localparam int FRAC_W    = 12;
  localparam int PROD_W    = 2 * WORD_W;
  // wide enough for a bias plus 256 products of two 16-bit words
  localparam int ACC_W     = 48;
  localparam int FEAT_SEL_W = 2;
  localparam int MAX_FEATURES = 4;
  localparam logic [WORD_W-1:0] HID_MAX = 16'h7fff;

  typedef struct packed {
    logic               func;
    logic [8:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
  } req_t;

  typedef struct packed {
    logic [1:0] predicted_class;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_L1,
    S_DRAIN1,
    S_L2,
    S_DRAIN2
  } state_t;

endpackage

// ----- rtl/mlpcls_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpcls request and response channels
// Valid/ready channels carrying classifier requests and predicted classes.
// ----------------------------------------------------------------------------
interface mlpcls_req_if ();
  logic              valid;
  logic              ready;
  mlpcls_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlpcls_rsp_if ();
  logic              valid;
  logic              ready;
  mlpcls_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mlp_relu_argmax_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_relu_argmax_classifier
// Fixed-point two-layer perceptron with ReLU hidden layer and argmax output.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per item. func = write stores weight_value at
//   weight_index (addresses beyond the store are dropped) and returns
//   nothing. func = classify runs the sample through both layers and returns
//   one transaction on rsp with predicted_class.
//   All arithmetic runs on one multiply-accumulate unit fed by the weight
//   store read port: one term per cycle, each unit being its bias plus its
//   terms. A classify runs layer one, drains the MAC pipeline, runs layer
//   two and drains the pipeline again before rsp valid. req.ready is held
//   low from acceptance until the classify finishes, so a new request waits
//   for the previous classify; a write leaves req.ready high, so a new
//   transaction can follow in the next cycle.
//   The result sits in an output register, so the next request is accepted
//   while rsp waits; a finished classify waits in its final drain until rsp
//   is free. Reset empties the pipeline and rsp; the weight store is not
//   cleared and must be written before use.
// ----------------------------------------------------------------------------
module mlp_relu_argmax_classifier #(
  parameter int N_FEATURES = 4,
  parameter int N_HIDDEN   = 32,
  parameter int N_CLASSES  = 3
) (
  input  logic          clk,
  input  logic          rst,
  mlpcls_req_if.sink    req,
  mlpcls_rsp_if.source  rsp
);

  localparam int OFS_B1     = N_FEATURES * N_HIDDEN;
  localparam int OFS_W2     = OFS_B1 + N_HIDDEN;
  localparam int OFS_B2     = OFS_W2 + N_HIDDEN * N_CLASSES;
  localparam int STORE_SIZE = OFS_B2 + N_CLASSES;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int HAW        = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
  localparam int MAX_UNITS  = (N_HIDDEN > N_CLASSES) ? N_HIDDEN : N_CLASSES;
  localparam int UW         = $clog2(MAX_UNITS);
  localparam int MAX_TERMS  = (N_FEATURES > N_HIDDEN) ? N_FEATURES : N_HIDDEN;
  localparam int TW         = $clog2(MAX_TERMS + 1);
  localparam int CW         = $clog2(N_CLASSES);
  localparam int W          = mlpcls_pkg::WORD_W;
  localparam int ACC_W      = mlpcls_pkg::ACC_W;
  localparam int PROD_W     = mlpcls_pkg::PROD_W;
  localparam int FRAC_W     = mlpcls_pkg::FRAC_W;

  typedef struct packed {
    logic                                v;
    logic                                first;
    logic                                last;
    logic                                layer2;
    logic [mlpcls_pkg::FEAT_SEL_W-1:0]   k;
    logic [UW-1:0]                       unit;
  } tag_t;

  mlpcls_pkg::state_t state, state_next;

  logic [W-1:0]        weight_mem [STORE_SIZE];
  logic [W-1:0]        hidden_mem [N_HIDDEN];
  logic [W-1:0]        w_q;
  logic [W-1:0]        hid_q;
  logic signed [W-1:0] feat [mlpcls_pkg::MAX_FEATURES];

  logic [UW-1:0]       unit_cnt;
  logic [TW-1:0]       term_cnt;
  logic                issue;
  logic                term_last;
  logic                unit_last;
  logic [AW-1:0]       rd_addr;
  logic [HAW-1:0]      hid_rd_addr;

  tag_t                p1, p2, p3, tag_issue;
  logic [ACC_W-1:0]    prod;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    best;
  logic [CW-1:0]       best_idx;

  logic                accept;
  logic                wr_en;
  logic [31:0]         wr_idx;
  logic                pipe_empty;
  logic                load_rsp;
  logic                hid_wr;
  logic [W-1:0]        hid_val;
  logic                rsp_valid;
  logic [1:0]          rsp_class;

  assign accept     = req.valid && req.ready;
  assign wr_idx     = 32'(req.data.weight_index);
  assign wr_en      = accept && (req.data.func == mlpcls_pkg::FUNC_WRITE) &&
                      (wr_idx < STORE_SIZE);
  assign pipe_empty = !p1.v && !p2.v && !p3.v;
  assign req.ready  = (state == mlpcls_pkg::S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.data.predicted_class = rsp_class;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlpcls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    load_rsp   = 1'b0;
    term_last  = 1'b0;
    unit_last  = 1'b0;
    unique case (state)
      mlpcls_pkg::S_IDLE: begin
        if (accept && req.data.func == mlpcls_pkg::FUNC_CLASSIFY) begin
          state_next = mlpcls_pkg::S_L1;
        end
      end
      mlpcls_pkg::S_L1: begin
        issue     = 1'b1;
        term_last = (term_cnt == TW'(N_FEATURES));
        unit_last = (unit_cnt == UW'(N_HIDDEN - 1));
        if (term_last && unit_last) begin
          state_next = mlpcls_pkg::S_DRAIN1;
        end
      end
      mlpcls_pkg::S_DRAIN1: begin
        if (pipe_empty) begin
          state_next = mlpcls_pkg::S_L2;
        end
      end
      mlpcls_pkg::S_L2: begin
        issue     = 1'b1;
        term_last = (term_cnt == TW'(N_HIDDEN));
        unit_last = (unit_cnt == UW'(N_CLASSES - 1));
        if (term_last && unit_last) begin
          state_next = mlpcls_pkg::S_DRAIN2;
        end
      end
      mlpcls_pkg::S_DRAIN2: begin
        if (pipe_empty && (!rsp_valid || rsp.ready)) begin
          load_rsp   = 1'b1;
          state_next = mlpcls_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mlpcls_pkg::S_IDLE;
      end
    endcase
  end

  // term and unit counters, term zero is the bias
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_cnt <= '0;
      term_cnt <= '0;
    end else if (accept) begin
      unit_cnt <= '0;
      term_cnt <= '0;
    end else if (issue) begin
      if (term_last) begin
        term_cnt <= '0;
        unit_cnt <= unit_last ? '0 : unit_cnt + 1'b1;
      end else begin
        term_cnt <= term_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    int a;
    int t;
    int u;
    t = int'(term_cnt);
    u = int'(unit_cnt);
    if (state == mlpcls_pkg::S_L2) begin
      a = (t == 0) ? OFS_B2 + u : OFS_W2 + (t - 1) * N_CLASSES + u;
    end else begin
      a = (t == 0) ? OFS_B1 + u : (t - 1) * N_HIDDEN + u;
    end
    rd_addr     = AW'(a);
    hid_rd_addr = HAW'(term_cnt - 1'b1);
    tag_issue.v      = issue;
    tag_issue.first  = (term_cnt == '0);
    tag_issue.last   = term_last;
    tag_issue.layer2 = (state == mlpcls_pkg::S_L2);
    tag_issue.k      = mlpcls_pkg::FEAT_SEL_W'(term_cnt - 1'b1);
    tag_issue.unit   = unit_cnt;
  end

  // weight store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[wr_idx[AW-1:0]] <= req.data.weight_value;
    end
    w_q <= weight_mem[rd_addr];
  end

  // hidden activations
  always_ff @(posedge clk) begin
    if (hid_wr) begin
      hidden_mem[HAW'(p3.unit)] <= hid_val;
    end
    hid_q <= hidden_mem[hid_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      feat[0] <= req.data.feature_0;
      feat[1] <= req.data.feature_1;
      feat[2] <= req.data.feature_2;
      feat[3] <= req.data.feature_3;
    end
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
      p2 <= '0;
      p3 <= '0;
    end else begin
      p1 <= tag_issue;
      p2 <= p1;
      p3 <= p2;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [W-1:0]      op;
    logic signed [PROD_W-1:0] mul;
    op  = p1.layer2 ? $signed(hid_q) : feat[p1.k];
    mul = op * $signed(w_q);
    if (p1.first) begin
      prod <= {{(ACC_W-W-FRAC_W){w_q[W-1]}}, w_q, {FRAC_W{1'b0}}};
    end else begin
      prod <= {{(ACC_W-PROD_W){mul[PROD_W-1]}}, mul};
    end
    acc <= p2.first ? prod : acc + prod;
  end

  // relu, rescale and saturate
  always_comb begin
    hid_wr = p3.v && p3.last && !p3.layer2;
    if (acc[ACC_W-1] || acc == '0) begin
      hid_val = '0;
    end else if (|acc[ACC_W-1:FRAC_W+W-1]) begin
      hid_val = mlpcls_pkg::HID_MAX;
    end else begin
      hid_val = acc[FRAC_W+W-1:FRAC_W];
    end
  end

  // argmax, a later class wins only on a strictly larger score
  always_ff @(posedge clk) begin
    if (p3.v && p3.last && p3.layer2) begin
      if (p3.unit == '0 || $signed(acc) > $signed(best)) begin
        best     <= acc;
        best_idx <= CW'(p3.unit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_class <= 2'(best_idx);
    end
  end

`ifndef ASSERT_OFF
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> pipe_empty)
    else $error("mac pipeline busy while accepting");

  a_hid_wr_layer1: assert property (@(posedge clk) disable iff (rst)
    hid_wr |-> (state == mlpcls_pkg::S_L1 || state == mlpcls_pkg::S_DRAIN1))
    else $error("hidden write outside layer one");

  a_rsp_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == mlpcls_pkg::S_DRAIN2)
    else $error("result raised outside final drain");

  a_layer2_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == mlpcls_pkg::S_L2 && $past(state) == mlpcls_pkg::S_DRAIN1)
      |-> $past(pipe_empty))
    else $error("layer two started before hidden values settled");
`endif

endmodule
